// ----- design/brb_pkg.sv -----
`default_nettype none

package brb_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
    logic load;
  } brb_ctrl_t;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] amount);
    logic [CNT_W-1:0] sum;
    sum = {1'b0, base} + amount;
    if (sum >= CNT_W'(DEPTH)) begin
      sum = sum - CNT_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/brb_ctrl.sv -----
`default_nettype none

module brb_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output brb_pkg::brb_ctrl_t     ctrl_o
);
  import brb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    ctrl_o      = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.exec = 1'b1;
          state_d     = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/brb_datapath.sv -----
`default_nettype none

module brb_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire brb_pkg::brb_ctrl_t                 ctrl_i,
  input  wire brb_pkg::cmd_e                      cmd_i,
  input  wire logic [7:0]                         data_byte_i,
  input  wire logic [brb_pkg::CNT_W-1:0]          pop_count_i,
  input  wire logic [brb_pkg::PTR_W-1:0]          read_offset_i,
  output logic [brb_pkg::OUT_DATA_W-1:0]          out_data_o
);
  import brb_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_q;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] done_q, done_d;
  logic             rvalid_q, rvalid_d;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] rd_addr;
  logic [CNT_W-1:0] pop_n;
  logic [CNT_W-1:0] to_end;
  logic [CNT_W-1:0] contig;
  logic [OUT_DATA_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    done_d   = '0;
    rvalid_d = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    pop_n    = (pop_count_i < fill_q) ? pop_count_i : fill_q;
    rd_addr  = wrap_add(rd_ptr_q, {1'b0, read_offset_i});
    if (ctrl_i.exec) begin
      case (cmd_i)
        CMD_PUSH: begin
          if (fill_q < CNT_W'(DEPTH)) begin
            mem_we   = 1'b1;
            wr_ptr_d = wrap_add(wr_ptr_q, CNT_W'(1));
            fill_d   = fill_q + CNT_W'(1);
            done_d   = CNT_W'(1);
          end
        end
        CMD_POP: begin
          rd_ptr_d = wrap_add(rd_ptr_q, pop_n);
          fill_d   = fill_q - pop_n;
          done_d   = pop_n;
        end
        CMD_READ: begin
          if ({1'b0, read_offset_i} < fill_q) begin
            mem_re   = 1'b1;
            rvalid_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q] <= data_byte_i;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      done_q   <= done_d;
      rvalid_q <= rvalid_d;
    end
  end

  assign to_end = CNT_W'(DEPTH) - {1'b0, rd_ptr_q};
  assign contig = (fill_q < to_end) ? fill_q : to_end;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      out_q <= {5'd0,
                (fill_q == '0),
                contig,
                fill_q,
                rvalid_q,
                rvalid_q ? rdata_q : 8'd0,
                done_q};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- design/byte_ring_buffer.sv -----
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: data_byte, pop_count, read_offset
// m_axis    out        tdata: done_count, read_byte, read_valid, fill_level,
//                      contiguous_len, is_empty
//
// Each command first updates the pointers and accesses the single-port byte
// memory, then loads the result register, so a new transfer is taken only
// after the result of the previous one has been loaded.
// A new transfer is taken while the previous result waits; the load of its
// result then stalls until the previous result has been taken.
// Reset clears the pointers and fill count; the byte memory is not cleared.

module byte_ring_buffer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] data_byte, [18:8] pop_count, [28:19] read_offset, [31:29] zero
  input  wire logic [brb_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [1:0]                      s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [10:0] done_count, [18:11] read_byte, [19] read_valid,
  // [30:20] fill_level, [41:31] contiguous_len, [42] is_empty, [47:43] zero
  output logic [brb_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o
);
  import brb_pkg::*;

  brb_ctrl_t ctrl;
  cmd_e      cmd;

  assign cmd = cmd_e'(s_axis_tuser_i);

  brb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .ctrl_o      (ctrl)
  );

  brb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (cmd),
    .data_byte_i   (s_axis_tdata_i[7:0]),
    .pop_count_i   (s_axis_tdata_i[18:8]),
    .read_offset_i (s_axis_tdata_i[28:19]),
    .out_data_o    (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_byte_ring_buffer.sv -----
`timescale 1ns / 100ps

module tb_byte_ring_buffer;
  import brb_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [CNT_W-1:0] done_count;
    logic [7:0]       read_byte;
    logic             read_valid;
    logic [CNT_W-1:0] fill_level;
    logic [CNT_W-1:0] contiguous_len;
    logic             is_empty;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tready;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [7:0] shadow_mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr = '0;
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [CNT_W-1:0] fill = '0;
  status_t pending_status [$];

  bit idle_en = 1'b0;
  int unsigned idle_cycles = 0;
  int errors = 0;
  int n_push = 0;
  int n_refused = 0;
  int n_pop = 0;
  int n_read = 0;
  int n_read_hit = 0;
  int n_unknown = 0;
  int n_checked = 0;

  byte_ring_buffer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic predict_status(input logic [1:0] op, input logic [7:0] data,
                                input logic [CNT_W-1:0] count,
                                input logic [PTR_W-1:0] offset);
    status_t st;
    int unsigned n;
    int unsigned to_end;
    st = '0;
    case (op)
      CMD_PUSH: begin
        n_push++;
        if (fill < DEPTH) begin
          shadow_mem[wr_ptr] = data;
          wr_ptr = PTR_W'((int'(wr_ptr) + 1) % DEPTH);
          fill = fill + 1'b1;
          st.done_count = 1;
        end else begin
          n_refused++;
        end
      end
      CMD_POP: begin
        n_pop++;
        n = (count < fill) ? count : fill;
        rd_ptr = PTR_W'((int'(rd_ptr) + n) % DEPTH);
        fill = fill - CNT_W'(n);
        st.done_count = CNT_W'(n);
      end
      CMD_READ: begin
        n_read++;
        if (offset < fill) begin
          n_read_hit++;
          st.read_byte = shadow_mem[PTR_W'((int'(rd_ptr) + int'(offset)) % DEPTH)];
          st.read_valid = 1'b1;
        end
      end
      default: begin
        n_unknown++;
      end
    endcase
    to_end = DEPTH - rd_ptr;
    st.fill_level = fill;
    st.contiguous_len = CNT_W'((fill < to_end) ? fill : to_end);
    st.is_empty = (fill == 0);
    pending_status.push_back(st);
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] data,
                          input logic [CNT_W-1:0] count, input logic [PTR_W-1:0] offset);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, offset, count, data};
    s_tuser <= op;
    do @(posedge clk_i); while (!s_tready);
    predict_status(op, data, count, offset);
  endtask

  task automatic send_random_cmd(input int unsigned push_pct, input int unsigned pop_pct,
                                 input bit big_pops);
    int unsigned roll;
    logic [1:0] op;
    logic [7:0] data;
    logic [CNT_W-1:0] count;
    logic [PTR_W-1:0] offset;
    roll = $urandom_range(0, 99);
    data = 8'($urandom);
    count = CNT_W'($urandom_range(0, DEPTH));
    offset = PTR_W'($urandom);
    if (roll < push_pct) begin
      op = CMD_PUSH;
    end else if (roll < push_pct + pop_pct) begin
      op = CMD_POP;
      if (big_pops) begin
        case ($urandom_range(0, 9))
          0: count = CNT_W'(DEPTH);
          1: count = '0;
          2, 3: count = CNT_W'($urandom_range(0, DEPTH));
          default: count = CNT_W'($urandom_range(1, 8));
        endcase
      end else begin
        count = CNT_W'($urandom_range(1, 3));
      end
    end else begin
      op = CMD_READ;
      if ($urandom_range(0, 3) != 0 && fill != 0) begin
        offset = PTR_W'($urandom_range(0, fill - 1));
      end
    end
    send_cmd(op, data, count, offset);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    idle_en = 1'b0;
    send_cmd(CMD_READ, 8'h00, '0, '0);
    send_cmd(CMD_POP, 8'h00, '0, '0);
    send_cmd(CMD_POP, 8'hFF, CNT_W'(DEPTH), '1);
    send_cmd(CMD_UNKNOWN, 8'hFF, CNT_W'(DEPTH), '1);
    send_cmd(CMD_PUSH, 8'h00, '0, '0);
    send_cmd(CMD_PUSH, 8'hFF, CNT_W'(DEPTH), '1);
    send_cmd(CMD_PUSH, 8'hA5, '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, 10'd0);
    send_cmd(CMD_READ, 8'h00, '0, 10'd1);
    send_cmd(CMD_READ, 8'h00, '0, 10'd2);
    send_cmd(CMD_READ, 8'h00, '0, 10'd3);
    send_cmd(CMD_READ, 8'hFF, '0, '1);
    send_cmd(CMD_POP, 8'h00, '0, '0);
    send_cmd(CMD_POP, 8'h00, 11'd1, '0);
    send_cmd(CMD_READ, 8'h00, '0, 10'd0);
    send_cmd(CMD_READ, 8'h00, '0, 10'd2);
    send_cmd(CMD_UNKNOWN, 8'h00, '0, '0);
    send_cmd(CMD_POP, 8'h00, CNT_W'(DEPTH), '0);
    send_cmd(CMD_READ, 8'h00, '0, 10'd0);
    send_cmd(CMD_PUSH, 8'h5A, '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, 10'd0);
  endtask

  // The sender stops until every outstanding result has been returned.
  task automatic test_sender_pause();
    idle_en = 1'b1;
    repeat (8) send_random_cmd(60, 15, 1'b1);
    drain_results();
    repeat (8) send_random_cmd(60, 15, 1'b1);
  endtask

  task automatic test_fill_and_wrap();
    int i;
    i = 0;
    while (fill < DEPTH) begin
      if (i % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      send_random_cmd(92, 2, 1'b0);
      i++;
    end
    repeat (4) send_cmd(CMD_PUSH, 8'($urandom), '0, '0);
    send_cmd(CMD_READ, 8'h00, '0, '1);
    send_cmd(CMD_READ, 8'h00, '0, '0);
    repeat (6) send_random_cmd(0, 0, 1'b0);
    send_cmd(CMD_POP, 8'h00, CNT_W'($urandom_range(100, 600)), '0);
    repeat (4) send_random_cmd(0, 0, 1'b0);
    send_cmd(CMD_POP, 8'h00, CNT_W'(DEPTH), '0);
    send_cmd(CMD_PUSH, 8'($urandom), '0, '0);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 250; i++) begin
      if (i >= 150) idle_en = 1'b0;
      else if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
      send_random_cmd(45, 20, 1'b1);
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      n_checked++;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tdata %h", $time, m_tdata);
      end else begin
        want = pending_status.pop_front();
        check_field("done_count", want.done_count, m_tdata[10:0]);
        check_field("read_byte", want.read_byte, m_tdata[18:11]);
        check_field("read_valid", want.read_valid, m_tdata[19]);
        check_field("fill_level", want.fill_level, m_tdata[30:20]);
        check_field("contiguous_len", want.contiguous_len, m_tdata[41:31]);
        check_field("is_empty", want.is_empty, m_tdata[42]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_sender_pause();
    test_fill_and_wrap();
    test_random_mix();
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d pushes (%0d refused when full), %0d pops, %0d reads (%0d in range).",
             n_push, n_refused, n_pop, n_read, n_read_hit);
    $display("Checked %0d results, including %0d unknown commands and a full fill with wrap.",
             n_checked, n_unknown);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
